// ===== hdl/aocl_pkg.sv =====
// package: depths, field types and operation codes of the open/closed list engine
`default_nettype none
package aocl_pkg;
    localparam int OPEN_DEPTH   = 64;
    localparam int CLOSED_DEPTH = 64;
    localparam int COORD_BITS   = 10;
    localparam int OCNT_W = $clog2(OPEN_DEPTH + 1);
    localparam int CCNT_W = $clog2(CLOSED_DEPTH + 1);

    localparam logic [1:0] KIND_PUSH_OPEN   = 2'd0;
    localparam logic [1:0] KIND_POP_OPEN    = 2'd1;
    localparam logic [1:0] KIND_PUSH_CLOSED = 2'd2;
    localparam logic [1:0] KIND_LOOKUP      = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic [1:0] WF_ABSENT = 2'd0;
    localparam logic [1:0] WF_OPEN   = 2'd1;
    localparam logic [1:0] WF_CLOSED = 2'd2;

    typedef logic [2*COORD_BITS-1:0] coord_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [9:0]  x;
        logic [9:0]  y;
        logic [15:0] heur;
        logic [15:0] cost;
        logic [9:0]  parent_x;
        logic [9:0]  parent_y;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  where_found;
        logic        open_empty;
        logic [9:0]  out_x;
        logic [9:0]  out_y;
        logic [15:0] out_heur;
        logic [15:0] out_cost;
        logic [9:0]  out_parent_x;
        logic [9:0]  out_parent_y;
    } out_item_t;

    // one open-list entry
    typedef struct packed {
        logic [15:0] key;
        coord_t      coord;
        logic [15:0] cost;
        coord_t      parent;
    } open_ent_t;

    // command broadcast to all open cells
    typedef struct packed {
        logic      push;
        logic      pop;
        open_ent_t ent;
    } open_cmd_t;
endpackage
`default_nettype wire

// ===== hdl/aocl_open_cell.sv =====
// open list cell: one sorted slot, shifts toward its neighbors on push and pop
`default_nettype none
module aocl_open_cell
    import aocl_pkg::*;
(
    input  wire logic      aclk,
    input  wire open_cmd_t cmd,
    input  wire logic      valid,      // this slot holds an entry
    input  wire logic      prev_ins,   // insertion point lies before this slot
    input  wire open_ent_t prev_ent,
    input  wire open_ent_t next_ent,
    input  wire coord_t    look_coord,
    output logic           ins,        // insertion point at or before this slot
    output logic           match,
    output open_ent_t      ent
);
    open_ent_t ent_reg, ent_next;
    logic      here;

    // slot takes new item if first with key >= heur, or empty
    assign here  = !valid || (ent_reg.key >= cmd.ent.key);
    assign ins   = prev_ins || here;
    assign match = valid && (ent_reg.coord == look_coord);
    assign ent   = ent_reg;

    always_comb begin
        ent_next = ent_reg;
        if (cmd.push) begin
            if (prev_ins) ent_next = prev_ent;
            else if (here) ent_next = cmd.ent;
        end else if (cmd.pop) begin
            ent_next = next_ent;
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg <= ent_next;
    end
endmodule
`default_nettype wire

// ===== hdl/aocl_closed_cell.sv =====
// closed set cell: one coordinate slot with its own compare
`default_nettype none
module aocl_closed_cell
    import aocl_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   wr,
    input  wire logic   valid,
    input  wire coord_t wr_coord,
    input  wire coord_t look_coord,
    output logic        match
);
    coord_t coord_reg;

    assign match = valid && (coord_reg == look_coord);

    // write on append to this slot
    always_ff @(posedge aclk) begin
        if (wr) coord_reg <= wr_coord;
    end
endmodule
`default_nettype wire

// ===== hdl/astar_open_closed_list_engine_top.sv =====
// top level: open list and closed set cell rows, control and result register
//
//   channel | ports        | direction | payload
//   input   | s_valid/ready| in        | in_item_t  s_data
//   result  | m_valid/ready| out       | out_item_t m_data
//
// one item per cycle while the result side is not stalled: every operation is computed in the
// cycle it is accepted and its result registered, the sorted cell row compares all slots in parallel
// the result register holds one item; a new item is taken when it is empty
// or being drained in the same cycle
// reset (aresetn low, synchronous) empties both stores at once
`default_nettype none
module astar_open_closed_list_engine_top
    import aocl_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data
);
    logic [OCNT_W-1:0] ocnt_reg, ocnt_next;
    logic [CCNT_W-1:0] ccnt_reg, ccnt_next;
    logic              mv_reg;
    out_item_t         mdata_reg, res;
    logic              acc;
    coord_t            key_coord, par_coord;
    open_cmd_t         ocmd;
    logic              ofull, cfull;

    open_ent_t ents  [OPEN_DEPTH];
    logic      oins  [OPEN_DEPTH];
    logic [OPEN_DEPTH-1:0]   omatch;
    logic [CLOSED_DEPTH-1:0] cmatch;

    assign s_ready = !mv_reg || m_ready;
    assign acc     = s_valid && s_ready;
    assign m_valid = mv_reg;
    assign m_data  = mdata_reg;

    assign key_coord = {s_data.x[COORD_BITS-1:0], s_data.y[COORD_BITS-1:0]};
    assign par_coord = {s_data.parent_x[COORD_BITS-1:0], s_data.parent_y[COORD_BITS-1:0]};
    assign ofull = (ocnt_reg == OCNT_W'(OPEN_DEPTH));
    assign cfull = (ccnt_reg == CCNT_W'(CLOSED_DEPTH));

    // command to open cells
    always_comb begin
        ocmd.push       = acc && (s_data.kind == KIND_PUSH_OPEN) && !ofull;
        ocmd.pop        = acc && (s_data.kind == KIND_POP_OPEN) && (ocnt_reg != '0);
        ocmd.ent.key    = s_data.heur;
        ocmd.ent.coord  = key_coord;
        ocmd.ent.cost   = s_data.cost;
        ocmd.ent.parent = par_coord;
    end

    // open list cell row
    genvar gi;
    generate
        for (gi = 0; gi < OPEN_DEPTH; gi++) begin : g_open
            logic      pins;
            open_ent_t pent, nent;
            if (gi == 0) begin : g_first
                assign pins = 1'b0;
                assign pent = '0;
            end else begin : g_mid
                assign pins = oins[gi-1];
                assign pent = ents[gi-1];
            end
            if (gi == OPEN_DEPTH-1) begin : g_last
                assign nent = '0;
            end else begin : g_nx
                assign nent = ents[gi+1];
            end
            aocl_open_cell u_cell (
                .aclk       (aclk),
                .cmd        (ocmd),
                .valid      (ocnt_reg > OCNT_W'(gi)),
                .prev_ins   (pins),
                .prev_ent   (pent),
                .next_ent   (nent),
                .look_coord (key_coord),
                .ins        (oins[gi]),
                .match      (omatch[gi]),
                .ent        (ents[gi])
            );
        end
        // closed set cell row
        for (gi = 0; gi < CLOSED_DEPTH; gi++) begin : g_closed
            aocl_closed_cell u_cell (
                .aclk       (aclk),
                .wr         (acc && (s_data.kind == KIND_PUSH_CLOSED) && !cfull
                             && (ccnt_reg == CCNT_W'(gi))),
                .valid      (ccnt_reg > CCNT_W'(gi)),
                .wr_coord   (key_coord),
                .look_coord (key_coord),
                .match      (cmatch[gi])
            );
        end
    endgenerate

    // result and count update
    always_comb begin
        res       = '0;
        ocnt_next = ocnt_reg;
        ccnt_next = ccnt_reg;
        unique case (s_data.kind)
            KIND_PUSH_OPEN: begin
                if (ofull) res.status = ST_FULL;
                else ocnt_next = ocnt_reg + 1'b1;
            end
            KIND_POP_OPEN: begin
                if (ocnt_reg == '0) begin
                    res.status = ST_EMPTY;
                end else begin
                    ocnt_next        = ocnt_reg - 1'b1;
                    res.out_x        = 10'(ents[0].coord[2*COORD_BITS-1:COORD_BITS]);
                    res.out_y        = 10'(ents[0].coord[COORD_BITS-1:0]);
                    res.out_heur     = ents[0].key;
                    res.out_cost     = ents[0].cost;
                    res.out_parent_x = 10'(ents[0].parent[2*COORD_BITS-1:COORD_BITS]);
                    res.out_parent_y = 10'(ents[0].parent[COORD_BITS-1:0]);
                end
            end
            KIND_PUSH_CLOSED: begin
                if (cfull) res.status = ST_FULL;
                else ccnt_next = ccnt_reg + 1'b1;
            end
            KIND_LOOKUP: begin
                if (|cmatch) res.where_found = WF_CLOSED;
                else if (|omatch) res.where_found = WF_OPEN;
            end
            default: ;
        endcase
        res.open_empty = (ocnt_next == '0);
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ocnt_reg <= '0;
            ccnt_reg <= '0;
            mv_reg   <= 1'b0;
        end else begin
            if (acc) begin
                ocnt_reg <= ocnt_next;
                ccnt_reg <= ccnt_next;
                mv_reg   <= 1'b1;
            end else if (m_ready) begin
                mv_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (acc) mdata_reg <= res;
    end
endmodule
`default_nettype wire

// ===== verif/astar_open_closed_list_engine_top_tb.sv =====
// testbench: open/closed list engine checked item by item against a behavioral queue model
`timescale 1ns / 100ps
`default_nettype none
module astar_open_closed_list_engine_top_tb;
    import aocl_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    astar_open_closed_list_engine_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // behavioral copy of both stores
    open_ent_t   open_row[$];
    coord_t      closed_row[$];
    out_item_t   pending_results[$];
    int          fail_count;
    int          idle_cycles;
    bit          hold_off;
    bit          sink_busy;
    int          hold_len;

    initial begin
        aclk = 1'b0;
    end
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // work out the result of one accepted item and update the stores
    function automatic out_item_t apply_item(in_item_t it);
        out_item_t r;
        open_ent_t e;
        coord_t    c;
        int        pos;
        r = '0;
        c = {it.x, it.y};
        case (it.kind)
            KIND_PUSH_OPEN: begin
                if (open_row.size() >= OPEN_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    e.key = it.heur;
                    e.coord = c;
                    e.cost = it.cost;
                    e.parent = {it.parent_x, it.parent_y};
                    pos = 0;
                    while (pos < open_row.size() && open_row[pos].key < it.heur) pos++;
                    open_row.insert(pos, e);
                end
            end
            KIND_POP_OPEN: begin
                if (open_row.size() == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    e = open_row.pop_front();
                    {r.out_x, r.out_y} = e.coord;
                    r.out_heur = e.key;
                    r.out_cost = e.cost;
                    {r.out_parent_x, r.out_parent_y} = e.parent;
                end
            end
            KIND_PUSH_CLOSED: begin
                if (closed_row.size() >= CLOSED_DEPTH) r.status = ST_FULL;
                else closed_row.push_back(c);
            end
            default: begin
                r.where_found = WF_ABSENT;
                foreach (open_row[i]) if (open_row[i].coord == c) r.where_found = WF_OPEN;
                foreach (closed_row[i]) if (closed_row[i] == c) r.where_found = WF_CLOSED;
            end
        endcase
        r.open_empty = (open_row.size() == 0);
        return r;
    endfunction

    // random gap, mostly short, now and then long
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // send one item and wait for it to be taken; valid drops only when a gap follows
    task automatic send_item(in_item_t it);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(apply_item(it));
    endtask

    function automatic in_item_t make_item(logic [1:0] k, int cspan);
        in_item_t it;
        it.kind = k;
        it.x = (cspan > 0) ? 10'($urandom_range(0, cspan)) : 10'($urandom);
        it.y = (cspan > 0) ? 10'($urandom_range(0, cspan)) : 10'($urandom);
        it.heur = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 7)) : 16'($urandom);
        it.cost = 16'($urandom);
        it.parent_x = 10'($urandom);
        it.parent_y = 10'($urandom);
        return it;
    endfunction

    // result side: random stall and a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_len <= 0;
        end else if (hold_off) begin
            m_ready <= 1'b0;
        end else if (hold_len > 0) begin
            hold_len <= hold_len - 1;
            m_ready <= 1'b0;
        end else if (!sink_busy && $urandom_range(0, 9) == 0) begin
            hold_len <= gap_len();
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with no expectation waiting");
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_data.status !== want.status) begin
                    $error("status exp %0d got %0d", want.status, m_data.status); fail_count++;
                end
                if (m_data.where_found !== want.where_found) begin
                    $error("where_found exp %0d got %0d", want.where_found, m_data.where_found);
                    fail_count++;
                end
                if (m_data.open_empty !== want.open_empty) begin
                    $error("open_empty exp %0d got %0d", want.open_empty, m_data.open_empty);
                    fail_count++;
                end
                if (m_data.out_x !== want.out_x) begin
                    $error("out_x exp %0d got %0d", want.out_x, m_data.out_x); fail_count++;
                end
                if (m_data.out_y !== want.out_y) begin
                    $error("out_y exp %0d got %0d", want.out_y, m_data.out_y); fail_count++;
                end
                if (m_data.out_heur !== want.out_heur) begin
                    $error("out_heur exp %0d got %0d", want.out_heur, m_data.out_heur);
                    fail_count++;
                end
                if (m_data.out_cost !== want.out_cost) begin
                    $error("out_cost exp %0d got %0d", want.out_cost, m_data.out_cost);
                    fail_count++;
                end
                if (m_data.out_parent_x !== want.out_parent_x) begin
                    $error("out_parent_x exp %0d got %0d", want.out_parent_x, m_data.out_parent_x);
                    fail_count++;
                end
                if (m_data.out_parent_y !== want.out_parent_y) begin
                    $error("out_parent_y exp %0d got %0d", want.out_parent_y, m_data.out_parent_y);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // directed: extremes of each field, every operation, empty stores
    task automatic test_directed();
        in_item_t it;
        it = '0;
        it.kind = KIND_POP_OPEN;
        send_item(it);
        it.kind = KIND_LOOKUP;
        send_item(it);
        it = '1;
        it.kind = KIND_PUSH_OPEN;
        send_item(it);
        it.heur = 16'hFFFF; it.x = 10'd0; it.y = 10'd0;
        send_item(it);
        it.heur = 16'd0; it.cost = 16'd0; it.parent_x = 10'd0; it.parent_y = 10'd0;
        send_item(it);
        it.kind = KIND_LOOKUP; it.x = 10'h3FF; it.y = 10'h3FF;
        send_item(it);
        it.kind = KIND_PUSH_CLOSED;
        send_item(it);
        it.kind = KIND_LOOKUP;
        send_item(it);
        it.x = 10'd1;
        send_item(it);
        repeat (4) begin
            it.kind = KIND_POP_OPEN;
            send_item(it);
        end
    endtask

    // fill both stores past their depth, run lookups, then drain the open list
    task automatic test_full_stores();
        repeat (OPEN_DEPTH + 3) send_item(make_item(KIND_PUSH_OPEN, 15));
        repeat (CLOSED_DEPTH + 3) send_item(make_item(KIND_PUSH_CLOSED, 15));
        repeat (20) send_item(make_item(KIND_LOOKUP, 15));
        repeat (OPEN_DEPTH + 2) send_item(make_item(KIND_POP_OPEN, 0));
    endtask

    // receiver holds off while the sender keeps offering items
    task automatic test_back_pressure();
        fork
            begin
                sink_busy = 1'b1;
                hold_off = 1'b1;
                repeat (60) @(posedge aclk);
                hold_off = 1'b0;
            end
            repeat (12) send_item(make_item(2'($urandom_range(0, 3)), 15));
        join
        sink_busy = 1'b0;
    endtask

    // random search-like traffic on a small grid so lookups hit
    task automatic test_random_traffic();
        int p;
        logic [1:0] k;
        repeat (400) begin
            p = $urandom_range(0, 99);
            if (p < 40) k = KIND_PUSH_OPEN;
            else if (p < 65) k = KIND_POP_OPEN;
            else if (p < 75) k = KIND_PUSH_CLOSED;
            else k = KIND_LOOKUP;
            send_item(make_item(k, ($urandom_range(0, 4) == 0) ? 0 : 15));
        end
    endtask

    initial begin
        fail_count = 0;
        hold_off = 1'b0;
        sink_busy = 1'b0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_back_pressure();
        test_full_stores();
        test_random_traffic();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
`default_nettype wire
